// ===== rtl/core/sbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbm_pkg;

  localparam int OFFSET_W = 23;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int REG_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 8'd16;
  localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 8'd16;

  localparam logic [OFFSET_W-1:0] HEADER_BYTES = 23'h10;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_PRG   = 2'd1,
    FUNC_CHR   = 2'd2,
    FUNC_RAM   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    WIN_CONTROL  = 2'd0,
    WIN_CHR_LOW  = 2'd1,
    WIN_CHR_HIGH = 2'd2,
    WIN_PRG      = 2'd3
  } window_t;

  typedef struct packed {
    logic [REG_W-1:0]   control;
    logic [REG_W-1:0]   chr_low;
    logic [REG_W-1:0]   chr_high;
    logic [REG_W-1:0]   prg;
    logic [COUNT_W-1:0] prg_count;
    logic [COUNT_W-1:0] chr_count;
  } sbm_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbm_loader.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbm_loader (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [1:0]                    func,
  input  wire logic [sbm_pkg::ADDR_W-1:0]    bus_addr,
  input  wire logic [sbm_pkg::DATA_W-1:0]    write_byte,
  input  wire logic                          cfg_we,
  input  wire logic [sbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbm_pkg::COUNT_W-1:0]   cfg_data,
  output sbm_pkg::sbm_state_t                state_next
);
  import sbm_pkg::*;

  logic [REG_W-1:0]   shift_bits;
  logic [2:0]         shift_count;
  logic [REG_W-1:0]   control;
  logic [REG_W-1:0]   chr_low;
  logic [REG_W-1:0]   chr_high;
  logic [REG_W-1:0]   prg;
  logic [COUNT_W-1:0] prg_count;
  logic [COUNT_W-1:0] chr_count;

  logic [REG_W-1:0]   shift_bits_next;
  logic [2:0]         shift_count_next;
  logic [REG_W-1:0]   shifted;
  logic [2:0]         count_inc;

  always_comb begin
    shifted          = {write_byte[0], shift_bits[REG_W-1:1]};
    count_inc        = 3'(shift_count + 3'd1);
    shift_bits_next  = shift_bits;
    shift_count_next = shift_count;
    state_next.control   = control;
    state_next.chr_low   = chr_low;
    state_next.chr_high  = chr_high;
    state_next.prg       = prg;
    state_next.prg_count = prg_count;
    state_next.chr_count = chr_count;
    if (func_t'(func) == FUNC_WRITE && bus_addr[ADDR_W-1]) begin
      if (write_byte[DATA_W-1]) begin
        shift_bits_next    = '0;
        shift_count_next   = '0;
        state_next.control = control | 5'h0C;
      end else if (count_inc == 3'd5) begin
        shift_bits_next  = '0;
        shift_count_next = '0;
        case (window_t'(bus_addr[14:13]))
          WIN_CONTROL:  state_next.control  = shifted;
          WIN_CHR_LOW:  state_next.chr_low  = shifted;
          WIN_CHR_HIGH: state_next.chr_high = shifted;
          default:      state_next.prg      = shifted;
        endcase
      end else begin
        shift_bits_next  = shifted;
        shift_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits  <= '0;
      shift_count <= '0;
      control     <= '0;
      chr_low     <= '0;
      chr_high    <= '0;
      prg         <= '0;
      prg_count   <= PRG_COUNT_RESET;
      chr_count   <= CHR_COUNT_RESET;
    end else begin
      if (advance) begin
        shift_bits  <= shift_bits_next;
        shift_count <= shift_count_next;
        control     <= state_next.control;
        chr_low     <= state_next.chr_low;
        chr_high    <= state_next.chr_high;
        prg         <= state_next.prg;
      end
      if (cfg_we && cfg_index == CFG_PRG_COUNT) begin
        prg_count <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_CHR_COUNT) begin
        chr_count <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbm_translate.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbm_translate (
  input  wire sbm_pkg::sbm_state_t          state,
  input  wire logic [1:0]                   func,
  input  wire logic [sbm_pkg::ADDR_W-1:0]   bus_addr,
  output logic [sbm_pkg::OFFSET_W-1:0]      image_offset,
  output logic                              offset_valid,
  output logic                              mirror_horizontal
);
  import sbm_pkg::*;

  logic [COUNT_W-1:0]  prg_bank;
  logic [OFFSET_W-1:0] chr_base;
  logic [16:0]         chr_inner;

  assign mirror_horizontal = (state.control[1:0] == 2'b11);

  always_comb begin
    if (!state.control[2]) begin
      prg_bank = bus_addr[14] ? {4'd0, state.prg[3:0]} : '0;
    end else begin
      prg_bank = bus_addr[14] ? 8'(state.prg_count - 8'd1) : {4'd0, state.prg[3:0]};
    end

    chr_base = HEADER_BYTES + {1'b0, state.prg_count, 14'd0};

    if (!state.control[4]) begin
      chr_inner = {state.chr_low[4:1], bus_addr[12:0]};
    end else if (bus_addr[15:12] == 4'd0) begin
      chr_inner = {state.chr_low, bus_addr[11:0]};
    end else if (bus_addr[15:12] == 4'd1) begin
      chr_inner = {state.chr_high, bus_addr[11:0]};
    end else begin
      chr_inner = '0;
    end

    image_offset = '0;
    offset_valid = 1'b0;
    case (func_t'(func))
      FUNC_PRG: begin
        offset_valid = 1'b1;
        if (!bus_addr[15]) begin
          image_offset = HEADER_BYTES;
        end else if (!state.control[3]) begin
          image_offset = HEADER_BYTES + {5'd0, state.prg[3:1], bus_addr[14:0]};
        end else begin
          image_offset = HEADER_BYTES + {1'b0, prg_bank, bus_addr[13:0]};
        end
      end
      FUNC_CHR: begin
        if (state.chr_count != '0) begin
          offset_valid = 1'b1;
          image_offset = chr_base + {6'd0, chr_inner};
        end
      end
      FUNC_RAM: begin
        offset_valid = 1'b1;
        image_offset = {1'b0, state.prg_count, 14'd0}
                     + {2'd0, state.chr_count, 13'd0}
                     + {7'd0, bus_addr};
      end
      default: begin
        image_offset = '0;
        offset_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/serial_bank_mapper_core.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   func, bus_addr, write_byte
// out      output     out_valid / out_stall image_offset, offset_valid,
//                                           mirror_horizontal
// cfg      input      cfg_we                cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; each word passes the input
// register, then loader update and translation into the result register.
// Synchronous reset clears the loader and bank registers and sets both
// bank counts to 16.
// out_stall backs up into in_stall in the same cycle once both registers hold.
`timescale 1ns / 1ps
`default_nettype none

module serial_bank_mapper_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    func,
  input  wire logic [sbm_pkg::ADDR_W-1:0]    bus_addr,
  input  wire logic [sbm_pkg::DATA_W-1:0]    write_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sbm_pkg::OFFSET_W-1:0]       image_offset,
  output logic                               offset_valid,
  output logic                               mirror_horizontal,
  input  wire logic                          cfg_we,
  input  wire logic [sbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbm_pkg::COUNT_W-1:0]   cfg_data
);
  import sbm_pkg::*;

  logic               s1_valid;
  logic [1:0]         s1_func;
  logic [ADDR_W-1:0]  s1_addr;
  logic [DATA_W-1:0]  s1_data;

  logic               out_free;
  logic               s1_fire;
  logic               in_fire;

  sbm_state_t         state_next;
  logic [OFFSET_W-1:0] calc_offset;
  logic               calc_valid;
  logic               calc_mirror;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func <= func;
      s1_addr <= bus_addr;
      s1_data <= write_byte;
    end
  end

  sbm_loader u_loader (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_fire),
    .func       (s1_func),
    .bus_addr   (s1_addr),
    .write_byte (s1_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .state_next (state_next)
  );

  sbm_translate u_translate (
    .state             (state_next),
    .func              (s1_func),
    .bus_addr          (s1_addr),
    .image_offset      (calc_offset),
    .offset_valid      (calc_valid),
    .mirror_horizontal (calc_mirror)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      image_offset      <= calc_offset;
      offset_valid      <= calc_valid;
      mirror_horizontal <= calc_mirror;
    end
  end

endmodule

`default_nettype wire

// ===== verif/sbm_checker.sv =====
`timescale 1ns / 1ps

module sbm_checker
  import sbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [1:0]            func,
  input  wire logic [ADDR_W-1:0]     bus_addr,
  input  wire logic [DATA_W-1:0]     write_byte,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [OFFSET_W-1:0]   image_offset,
  input  wire logic                  offset_valid,
  input  wire logic                  mirror_horizontal,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COUNT_W-1:0]    cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked
);

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                valid;
    logic                mirror;
  } map_result_t;

  map_result_t expected_q[$];

  logic [REG_W-1:0]   loader_bits;
  logic [2:0]         loader_count;
  logic [REG_W-1:0]   control_r;
  logic [REG_W-1:0]   chr_low_r;
  logic [REG_W-1:0]   chr_high_r;
  logic [REG_W-1:0]   prg_r;
  logic [COUNT_W-1:0] prg_count_r;
  logic [COUNT_W-1:0] chr_count_r;

  task automatic apply_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    if (!a[15]) return;
    if (d[7]) begin
      loader_bits  = '0;
      loader_count = '0;
      control_r    = control_r | 5'h0C;
      return;
    end
    loader_bits  = {d[0], loader_bits[4:1]};
    loader_count = loader_count + 3'd1;
    if (loader_count == 3'd5) begin
      case (window_t'(a[14:13]))
        WIN_CONTROL:  control_r  = loader_bits;
        WIN_CHR_LOW:  chr_low_r  = loader_bits;
        WIN_CHR_HIGH: chr_high_r = loader_bits;
        default:      prg_r      = loader_bits;
      endcase
      loader_bits  = '0;
      loader_count = '0;
    end
  endtask

  function automatic logic [31:0] prg_offset(input logic [ADDR_W-1:0] a);
    logic [31:0] bank;
    if (!a[15]) return 32'(HEADER_BYTES);
    if (!control_r[3]) return 32'(HEADER_BYTES) + prg_r[3:1] * 32'h8000 + a[14:0];
    if (!control_r[2]) bank = a[14] ? prg_r[3:0] : 32'd0;
    else bank = a[14] ? {24'd0, prg_count_r - 8'd1} : prg_r[3:0];
    return 32'(HEADER_BYTES) + bank * 32'h4000 + a[13:0];
  endfunction

  function automatic logic [31:0] chr_offset(input logic [ADDR_W-1:0] a);
    logic [31:0] inner;
    inner = 32'd0;
    if (control_r[4]) begin
      if (a <= 16'h0fff) inner = chr_low_r * 32'h1000 + a[11:0];
      else if (a <= 16'h1fff) inner = chr_high_r * 32'h1000 + a[11:0];
    end else begin
      inner = chr_low_r[4:1] * 32'h2000 + a[12:0];
    end
    return 32'(HEADER_BYTES) + prg_count_r * 32'h4000 + inner;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
  endtask

  always @(posedge clk) begin : watch
    map_result_t want;
    map_result_t got;
    logic [31:0] full;
    if (rst) begin
      loader_bits     = '0;
      loader_count    = '0;
      control_r       = '0;
      chr_low_r       = '0;
      chr_high_r      = '0;
      prg_r           = '0;
      prg_count_r     = PRG_COUNT_RESET;
      chr_count_r     = CHR_COUNT_RESET;
      fail_count      = 0;
      results_checked = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PRG_COUNT) prg_count_r = cfg_data;
        else if (cfg_index == CFG_CHR_COUNT) chr_count_r = cfg_data;
      end

      if (out_valid && !out_stall) begin
        got.offset = image_offset;
        got.valid  = offset_valid;
        got.mirror = mirror_horizontal;
        if (expected_q.size() == 0) begin
          fail_count++;
          $error("result word with no expectation waiting: offset 0x%0h", image_offset);
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (got.offset !== want.offset) note_mismatch("image_offset", want.offset, got.offset);
          if (got.valid !== want.valid) note_mismatch("offset_valid", want.valid, got.valid);
          if (got.mirror !== want.mirror)
            note_mismatch("mirror_horizontal", want.mirror, got.mirror);
        end
      end

      if (in_valid && !in_stall) begin
        full       = 32'd0;
        want.valid = 1'b0;
        case (func_t'(func))
          FUNC_WRITE: apply_write(bus_addr, write_byte);
          FUNC_PRG: begin
            full       = prg_offset(bus_addr);
            want.valid = 1'b1;
          end
          FUNC_CHR: begin
            if (chr_count_r != '0) begin
              full       = chr_offset(bus_addr);
              want.valid = 1'b1;
            end
          end
          default: begin
            full       = prg_count_r * 32'h4000 + chr_count_r * 32'h2000 + bus_addr;
            want.valid = 1'b1;
          end
        endcase
        want.offset = full[OFFSET_W-1:0];
        want.mirror = (control_r[1:0] == 2'b11);
        expected_q.push_back(want);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sbm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_WORDS   = 105;
  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 6;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           func;
  logic [ADDR_W-1:0]    bus_addr;
  logic [DATA_W-1:0]    write_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [OFFSET_W-1:0]  image_offset;
  logic                 offset_valid;
  logic                 mirror_horizontal;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int results_checked;
  int words_sent;
  int settings_done;
  bit calm;
  bit hold_req;

  serial_bank_mapper_core dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .bus_addr          (bus_addr),
    .write_byte        (write_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .image_offset      (image_offset),
    .offset_valid      (offset_valid),
    .mirror_horizontal (mirror_horizontal),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  sbm_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .bus_addr          (bus_addr),
    .write_byte        (write_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .image_offset      (image_offset),
    .offset_valid      (offset_valid),
    .mirror_horizontal (mirror_horizontal),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_checked   (results_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 4);
  endfunction

  // output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send_word(input func_t f, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
    int gap;
    in_valid   <= 1'b1;
    func       <= f;
    bus_addr   <= a;
    write_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input logic [COUNT_W-1:0] prg, input logic [COUNT_W-1:0] chr);
    drain_words();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE_2;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_index <= CFG_SPARE_3;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_index <= CFG_PRG_COUNT;
    cfg_data  <= prg;
    @(posedge clk);
    cfg_index <= CFG_CHR_COUNT;
    cfg_data  <= chr;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // mostly loader writes in the mapper window so the registers keep changing
  task automatic send_random_word();
    int pick;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    func_t f;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    f = FUNC_WRITE;
    if (pick < 45) begin
      a[15] = 1'b1;
      d[7]  = 1'b0;
    end else if (pick < 50) begin
      a[15] = 1'b1;
      d[7]  = 1'b1;
    end else if (pick >= 55) begin
      f = func_t'($urandom_range(1, 3));
      if (f == FUNC_PRG && pick < 90) a[15] = 1'b1;
      if (f == FUNC_CHR && pick < 90) a[15:13] = 3'b000;
    end
    send_word(f, a, d);
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] prg_set;
    logic [COUNT_W-1:0] chr_set;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = FUNC_WRITE;
    bus_addr   = '0;
    write_byte = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_PRG_COUNT;
    cfg_data   = '0;
    calm       = 1'b1;
    hold_req   = 1'b0;
    words_sent    = 0;
    settings_done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset state, edges of each window
    send_word(FUNC_PRG, 16'h0000, 8'h00);
    send_word(FUNC_PRG, 16'h7fff, 8'hff);
    send_word(FUNC_PRG, 16'h8000, 8'h00);
    send_word(FUNC_PRG, 16'hffff, 8'h00);
    send_word(FUNC_CHR, 16'h0000, 8'h00);
    send_word(FUNC_CHR, 16'h1fff, 8'h00);
    send_word(FUNC_CHR, 16'hffff, 8'h00);
    send_word(FUNC_RAM, 16'h0000, 8'h00);
    send_word(FUNC_RAM, 16'hffff, 8'hff);
    send_word(FUNC_WRITE, 16'h7fff, 8'h01);
    send_word(FUNC_WRITE, 16'h8000, 8'h80);
    // control = 0x1f: 16K fixed-last, 4K chr, horizontal mirror
    for (int i = 0; i < 5; i++) send_word(FUNC_WRITE, 16'h8000 + 16'(i) * 16'h07ff, 8'h7f);
    send_word(FUNC_PRG, 16'hbfff, 8'h00);
    send_word(FUNC_PRG, 16'hc000, 8'h00);
    send_word(FUNC_CHR, 16'h0fff, 8'h00);
    send_word(FUNC_CHR, 16'h1000, 8'h00);
    send_word(FUNC_CHR, 16'h2000, 8'h00);
    send_word(FUNC_WRITE, 16'hffff, 8'hff);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin prg_set = 8'd16;  chr_set = 8'd16;  end
        1: begin prg_set = 8'd255; chr_set = 8'd255; end
        2: begin prg_set = 8'd1;   chr_set = 8'd0;   end
        3: begin prg_set = 8'd0;   chr_set = 8'd1;   end
        5: begin prg_set = 8'd2;   chr_set = 8'd128; end
        default: begin
          prg_set = 8'($urandom_range(1, 255));
          chr_set = 8'($urandom_range(0, 255));
        end
      endcase
      set_counts(prg_set, chr_set);
      calm = (phase == 0) || (phase == 5);
      if (phase == 5) hold_req = 1'b1;
      repeat (PHASE_WORDS) send_random_word();
    end

    drain_words();
    $display("Sent %0d words under %0d bank-count settings; %0d results checked.",
             words_sent, settings_done, results_checked);
    $display("Settings included zero CHR banks, zero PRG banks and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
